// File: rtl/cfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared constants, types and the field layout table for the deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int FRAME_BYTES = 48;
	localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
	localparam int SUM_FIRST   = 2;
	localparam int SUM_LAST    = 44;
	localparam int SUM_POS     = 45;
	localparam int TAIL_POS0   = FRAME_BYTES - 2;
	localparam int TAIL_POS1   = FRAME_BYTES - 1;
	localparam int PAY_BYTES   = SUM_LAST - SUM_FIRST + 1;
	localparam int NUM_FIELDS  = 25;
	localparam int IDX_W       = 5;
	localparam int VAL_W       = 17;

	typedef logic [7:0]       byte_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [1:0]       kind_t;

	localparam byte_t HEAD0      = 8'hD1;
	localparam byte_t HEAD1      = 8'h5B;
	localparam byte_t TAIL0      = 8'h6B;
	localparam byte_t TAIL1      = 8'h1D;
	localparam byte_t VISION_BIT = 8'h01;

	localparam idx_t LAST_IDX = idx_t'(NUM_FIELDS - 1);

	localparam kind_t KIND_U8  = 2'd0;
	localparam kind_t KIND_U16 = 2'd1;
	localparam kind_t KIND_S16 = 2'd2;

	// Fields tile the payload bytes in order, so only the width of each one
	// is needed to walk through them.
	function automatic kind_t fld_kind(input idx_t idx);
		kind_t k;
		case (idx) inside
			5'd0, 5'd1, 5'd10, 5'd11, 5'd16, 5'd19, 5'd20: k = KIND_U8;
			5'd2, 5'd3, 5'd8, 5'd9:                        k = KIND_U16;
			default:                                       k = KIND_S16;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/checksummed_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_deframer
// Serial byte deframer with sync header, tail and XOR checksum check.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. Once 48 bytes have gathered since the last good
// frame, the window is checked in the next cycle (bytes keep flowing in); a
// good frame is copied into the field walker, which emits its 25 fields at one
// per cycle while out_ready is high, through a registered output. A failed check
// slides the window by one byte. Input ready drops only when a second good
// frame is complete while the walker is still emitting the previous one, which
// can happen only if the output side stalls while that frame is emitted.
module checksummed_frame_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  cfd_pkg::byte_t                    rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output cfd_pkg::idx_t                     field_index,
	output logic signed [cfd_pkg::VAL_W-1:0]  field_value,
	output logic                              last_field,
	output logic                              vision_on,
	output logic                              enable_changed
);
	import cfd_pkg::*;

	logic  launch;
	logic  emit_busy;
	byte_t pay [PAY_BYTES];

	cfd_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.emit_busy (emit_busy),
		.launch    (launch),
		.pay       (pay)
	);

	cfd_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.launch         (launch),
		.pay            (pay),
		.busy           (emit_busy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.field_index    (field_index),
		.field_value    (field_value),
		.last_field     (last_field),
		.vision_on      (vision_on),
		.enable_changed (enable_changed)
	);

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_field == (field_index == LAST_IDX)))
		else $error("last_field does not match the final field index");

	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_field) |=>
		(out_valid && field_index == $past(field_index) + idx_t'(1)
		&& vision_on == $past(vision_on)))
		else $error("field run broke before its last word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (emit_busy && out_valid))
		else $error("input stalled without a pending result");

endmodule

// File: rtl/cfd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_window
// Byte shift register with fill tracking, running checksum and frame check.
// ----------------------------------------------------------------------------
module cfd_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cfd_pkg::byte_t              rx_byte,
	input  logic                        emit_busy,
	output logic                        launch,
	output cfd_pkg::byte_t              pay [cfd_pkg::PAY_BYTES]
);
	import cfd_pkg::*;

	byte_t             sr_q [FRAME_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] written_q;
	byte_t             sum_q;

	logic              full;
	logic              match;
	logic              take;
	logic [FILL_W-1:0] fill_base;
	byte_t             sum_d;

	// The window is always the newest fill_q bytes of the shift register; a
	// check is only due when it spans the whole register.
	assign full  = (fill_q == FILL_W'(FRAME_BYTES));
	assign match = full && (sr_q[0] == HEAD0) && (sr_q[1] == HEAD1)
		&& (sr_q[TAIL_POS0] == TAIL0) && (sr_q[TAIL_POS1] == TAIL1)
		&& (sum_q == sr_q[SUM_POS]);

	assign in_ready = !(match && emit_busy);
	assign launch   = match && !emit_busy;
	assign take     = in_valid && in_ready;

	always_comb begin
		if (full) begin
			fill_base = match ? '0 : FILL_W'(FRAME_BYTES - 1);
		end else begin
			fill_base = fill_q;
		end
	end

	// The checksum register covers only bytes written since reset, so stale
	// register contents never enter it.
	always_comb begin
		sum_d = sum_q;
		if (written_q >= FILL_W'(FRAME_BYTES - SUM_FIRST)) begin
			sum_d = sum_d ^ sr_q[SUM_FIRST];
		end
		if (written_q >= FILL_W'(FRAME_BYTES - SUM_POS)) begin
			sum_d = sum_d ^ sr_q[SUM_POS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			written_q <= '0;
			sum_q     <= '0;
		end else begin
			if (!(match && emit_busy)) begin
				fill_q <= fill_base + {{(FILL_W-1){1'b0}}, take};
			end
			if (take) begin
				sum_q <= sum_d;
				if (written_q != FILL_W'(FRAME_BYTES)) begin
					written_q <= written_q + {{(FILL_W-1){1'b0}}, 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				sr_q[i] <= sr_q[i+1];
			end
			sr_q[FRAME_BYTES-1] <= rx_byte;
		end
	end

	always_comb begin
		for (int i = 0; i < PAY_BYTES; i++) begin
			pay[i] = sr_q[SUM_FIRST + i];
		end
	end

endmodule

// File: rtl/cfd_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_emit
// Holds an accepted frame and walks its fields into the output register.
// ----------------------------------------------------------------------------
module cfd_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              launch,
	input  cfd_pkg::byte_t                    pay [cfd_pkg::PAY_BYTES],
	output logic                              busy,
	output logic                              out_valid,
	input  logic                              out_ready,
	output cfd_pkg::idx_t                     field_index,
	output logic signed [cfd_pkg::VAL_W-1:0]  field_value,
	output logic                              last_field,
	output logic                              vision_on,
	output logic                              enable_changed
);
	import cfd_pkg::*;

	byte_t            pay_q [PAY_BYTES];
	byte_t            pay_d [PAY_BYTES];
	logic             busy_q;
	idx_t             idx_q;
	logic             von_q;
	logic             chg_q;
	logic             prev_von_q;
	logic             out_valid_q;

	logic             advance;
	logic             new_von;
	kind_t            kind;
	logic [VAL_W-1:0] value;

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign advance   = busy_q && (!out_valid_q || out_ready);
	assign new_von   = |(pay[0] & VISION_BIT);
	assign kind      = fld_kind(idx_q);

	always_comb begin
		case (kind)
			KIND_U8:  value = {9'd0, pay_q[0]};
			KIND_U16: value = {1'b0, pay_q[1], pay_q[0]};
			default:  value = {pay_q[1][7], pay_q[1], pay_q[0]};
		endcase
	end

	// Consume one or two bytes from the front, depending on the field width.
	always_comb begin
		for (int i = 0; i < PAY_BYTES; i++) begin
			pay_d[i] = pay_q[i];
			if (kind == KIND_U8) begin
				if (i + 1 < PAY_BYTES) begin
					pay_d[i] = pay_q[i+1];
				end
			end else begin
				if (i + 2 < PAY_BYTES) begin
					pay_d[i] = pay_q[i+2];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			prev_von_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (launch) begin
				busy_q     <= 1'b1;
				idx_q      <= '0;
				prev_von_q <= new_von;
			end else if (advance) begin
				idx_q <= idx_q + idx_t'(1);
				if (idx_q == LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			pay_q <= pay;
			von_q <= new_von;
			chg_q <= new_von ^ prev_von_q;
		end else if (advance) begin
			pay_q <= pay_d;
		end
		if (advance) begin
			field_index    <= idx_q;
			field_value    <= value;
			last_field     <= (idx_q == LAST_IDX);
			vision_on      <= von_q;
			enable_changed <= chg_q;
		end
	end

endmodule
